### design/csm_pkg.sv
// Package with the shared types, constants and tables of the column softmax block.
package csm_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUM,
    ST_EMIT,
    ST_DIV,
    ST_OUT
  } csm_state_t;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_PREP,
    EX_ROOT,
    EX_ROUND
  } exp_phase_t;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [16:0] PROB_ONE  = 17'd65536;

  function automatic logic [31:0] root_entry(input logic [3:0] j);
    logic [31:0] r;
    unique case (j)
      4'd1:    r = 32'd1518500250;
      4'd2:    r = 32'd1805811302;
      4'd3:    r = 32'd1969251188;
      4'd4:    r = 32'd2056437386;
      4'd5:    r = 32'd2101467501;
      4'd6:    r = 32'd2124351003;
      4'd7:    r = 32'd2135885998;
      4'd8:    r = 32'd2141676973;
      4'd9:    r = 32'd2144578345;
      4'd10:   r = 32'd2146030506;
      4'd11:   r = 32'd2146756953;
      4'd12:   r = 32'd2147120270;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

endpackage

### design/csm_ram.sv
// Generic single-port-write, registered-read RAM.
module csm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/csm_exp.sv
// Sequential exponential unit: 2^(-d*log2 e) by a root table, one table step a cycle.
module csm_exp #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] diff,
  output logic        done,
  output logic [16:0] result
);
  import csm_pkg::*;

  localparam int CW = $clog2(EXP_TABLE_BITS + 2);

  exp_phase_t                phase, phase_next;
  logic [32:0]               prod;
  logic [32:0]               prod_next;
  logic [EXP_TABLE_BITS-1:0] frac;
  logic [8:0]                kint;
  logic [31:0]               mant;
  logic [CW-1:0]             step;
  logic [63:0]               mul;
  logic [4:0]                shamt;
  logic [32:0]               rounded;

  assign prod_next = 33'({17'd0, diff} * {16'd0, LOG2E_Q16});
  assign mul       = 64'(mant) * 64'(root_entry(4'(step)));
  assign shamt     = 5'(9'd15 + kint);
  assign rounded   = (33'(mant) + (33'd1 << (shamt - 5'd1))) >> shamt;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      EX_IDLE: if (start) phase_next = EX_PREP;
      EX_PREP: phase_next = EX_ROOT;
      EX_ROOT: if (step == CW'(EXP_TABLE_BITS)) phase_next = EX_ROUND;
      default: phase_next = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= EX_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= 1'b0;
      unique case (phase)
        EX_IDLE: begin
          if (start) begin
            prod <= prod_next;
          end
        end
        EX_PREP: begin
          kint <= prod[32:24];
          frac <= prod[23 -: EXP_TABLE_BITS];
          mant <= 32'h8000_0000;
          step <= CW'(1);
        end
        EX_ROOT: begin
          // The fraction is consumed from its top bit down, one root per step.
          if (frac[EXP_TABLE_BITS-1]) begin
            mant <= 32'((mul + 64'd1073741824) >> 31);
          end
          frac <= frac << 1;
          if (step != CW'(EXP_TABLE_BITS)) begin
            step <= step + CW'(1);
          end
        end
        default: begin
          result <= (kint > 9'd16) ? 17'd0 : 17'(rounded);
          done   <= 1'b1;
        end
      endcase
    end
  end

endmodule

### design/column_softmax_top.sv
// Top level of the column softmax block.
// Loading accepts one score per cycle. On the closing transfer the column is
// swept twice: first for the exponential sum, then for exponential and
// 24-step division per score, each result transfer waiting for m_tready.
// The exponential unit and the restoring divider set the time per score.
// Synchronous active-high reset empties the column; the store holds no reset.
module column_softmax_top #(
  parameter int MAX_LEN        = 64,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: score_value[15:0]; s_tlast: column_end.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tlast,
  // m_tdata: probability[16:0], zero filled to 24 bits; m_tlast: final_result;
  // m_tuser: overflow_seen.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);
  import csm_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  csm_state_t state, state_next;

  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic signed [15:0]   running_max;
  logic [23:0]          exp_sum;
  logic                 dropped;
  logic                 rd_wait;
  logic                 exp_busy;
  logic [AW-1:0]        rd_addr;
  logic [15:0]          rd_data;
  logic                 wr_en;
  logic                 exp_start;
  logic                 exp_done;
  logic [16:0]          exp_val;
  logic [15:0]          diff;
  logic [32:0]          dividend;
  logic [40:0]          rem;
  logic [40:0]          num;
  logic [16:0]          quot;
  logic [4:0]           div_step;
  logic [41:0]          trial;
  logic [16:0]          prob;
  logic                 last_out;

  // The store is only written during loading, while the fill count is below MAX_LEN.
  assign s_tready = (state == ST_LOAD);
  assign wr_en    = s_tvalid && s_tready && (count < CW'(MAX_LEN));

  csm_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(count)),
    .wr_data (s_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_addr   = AW'(idx);
  assign diff      = 16'(running_max - $signed(rd_data));
  assign exp_start = rd_wait;

  csm_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
    .clk    (clk),
    .rst    (rst),
    .start  (exp_start),
    .diff   (diff),
    .done   (exp_done),
    .result (exp_val)
  );

  // Rounded numerator e * 65536 + sum / 2. The quotient never exceeds 65536,
  // so the bits above the low 24 are always below the sum and can seed the
  // remainder, leaving 24 restoring steps of one bit a cycle.
  assign dividend = {exp_val, 16'd0} + 33'(exp_sum >> 1);
  assign trial    = {rem, num[40]} - {18'd0, exp_sum};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (s_tvalid && s_tlast) state_next = ST_SUM;
      ST_SUM:  if (exp_done && idx == count - CW'(1)) state_next = ST_EMIT;
      ST_EMIT: if (exp_done) state_next = ST_DIV;
      ST_DIV:  if (div_step == 5'd0) state_next = ST_OUT;
      default: if (m_tready) state_next = last_out ? ST_LOAD : ST_EMIT;
    endcase
  end

  always_comb begin
    m_tvalid = (state == ST_OUT);
    m_tdata  = {7'd0, prob};
    m_tlast  = last_out;
    m_tuser  = dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      count       <= '0;
      idx         <= '0;
      running_max <= -16'sd32768;
      exp_sum     <= '0;
      dropped     <= 1'b0;
      rd_wait     <= 1'b0;
      exp_busy    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_wait <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            if (wr_en) begin
              count <= count + CW'(1);
              if ($signed(s_tdata) > running_max) running_max <= $signed(s_tdata);
            end else begin
              dropped <= 1'b1;
            end
            idx      <= '0;
            exp_sum  <= '0;
            exp_busy <= 1'b0;
          end
        end
        ST_SUM, ST_EMIT: begin
          if (!exp_busy) begin
            exp_busy <= 1'b1;
            rd_wait  <= 1'b1;
          end
          if (exp_done) begin
            exp_busy <= 1'b0;
            if (state == ST_SUM) begin
              exp_sum <= exp_sum + 24'(exp_val);
              idx     <= (idx == count - CW'(1)) ? '0 : idx + CW'(1);
            end else begin
              num      <= {dividend[23:0], 17'd0};
              rem      <= 41'(dividend[32:24]);
              div_step <= 5'd23;
            end
          end
        end
        ST_DIV: begin
          num <= {num[39:0], 1'b0};
          if (!trial[41]) begin
            rem  <= trial[40:0];
            quot <= {quot[15:0], 1'b1};
          end else begin
            rem  <= {rem[39:0], num[40]};
            quot <= {quot[15:0], 1'b0};
          end
          if (div_step != 5'd0) div_step <= div_step - 5'd1;
          last_out <= (idx == count - CW'(1));
        end
        default: begin
          if (m_tready) begin
            idx <= idx + CW'(1);
            if (last_out) begin
              count       <= '0;
              running_max <= -16'sd32768;
              exp_sum     <= '0;
              dropped     <= 1'b0;
            end
          end
        end
      endcase
    end
  end

  // The quotient sits in the low bits; it is held to one at most.
  always_comb begin
    if (exp_sum == 24'd0) prob = 17'd0;
    else prob = (quot > PROB_ONE) ? PROB_ONE : quot;
  end

endmodule
